@@ rtl/slwc_pkg.sv @@
// Shared types, codes and constants for the stop-and-wait link client.
// No dependencies; every other file of the block but slwc_ram imports this package.
`default_nettype none

package slwc_pkg;

   // Limits that the write request checks against.
   localparam int HANDLE_COUNT = 256;
   localparam int MAX_PAYLOAD  = 1024;

   // Result queue between the core and the response port.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Stream data widths, padded to whole bytes.
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 64;

   // Configuration register indexes.
   localparam logic [0:0] CSR_EPOCH_LIMIT = 1'b0;
   localparam logic [0:0] CSR_CONN_ID     = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_PACKET = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      KIND_ACK     = 3'd0,
      KIND_SEND    = 3'd1,
      KIND_DELIVER = 3'd2,
      KIND_DOWN    = 3'd3,
      KIND_REJECT  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] seq;
      logic [15:0] conn;
      logic [7:0]  handle;
      logic        last;
   } rsp_item_type;

   // Up to three results produced by one request in a single cycle.
   typedef struct packed {
      logic [1:0]              count;
      rsp_item_type [2:0]      item;
   } rsp_push_type;

   function automatic rsp_item_type make_item(kind_type kind, logic [31:0] seq,
                                              logic [15:0] conn, logic [7:0] handle);
      rsp_item_type r;
      r.kind   = kind;
      r.seq    = seq;
      r.conn   = conn;
      r.handle = handle;
      r.last   = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/slwc_ram.sv @@
// Generic synchronous RAM: one write port, two read ports, registered reads.
// Reads return the contents before a write at the same edge. No dependencies.
`default_nettype none

module slwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]  rd_data_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

@@ rtl/slwc_rsp_fifo.sv @@
// Result queue: takes up to three results a cycle, hands out one a cycle while out_ready is high.
// Depends on slwc_pkg.
`default_nettype none

module slwc_rsp_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire slwc_pkg::rsp_push_type        push,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output slwc_pkg::rsp_item_type             out_item,
   output logic [slwc_pkg::RSP_CNT_W-1:0]     fill
);
   import slwc_pkg::*;

   rsp_item_type           mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign fill      = count_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push.count) begin
            mem_ff[wr_ptr_ff + RSP_PTR_W'(i)] <= push.item[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/slwc_core.sv @@
// Protocol core: link state registers, the payload queue in RAM with
// forwarding, and the per-request decision logic. Depends on slwc_pkg, slwc_ram.
`default_nettype none

module slwc_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [0:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   input  wire logic              in_accept,
   input  wire logic [1:0]        in_op,
   input  wire logic [15:0]       in_conn,
   input  wire logic [31:0]       in_seq,
   input  wire logic [9:0]        in_length,
   input  wire logic [7:0]        in_handle,
   output logic                   busy,
   output slwc_pkg::rsp_push_type push
);
   import slwc_pkg::*;

   localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = 40;

   function automatic logic [IDX_W-1:0] next_idx(logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   // Configuration.
   logic [7:0]  epoch_limit_ff;
   logic [15:0] conn_id_ff;

   // Request under processing.
   logic        stage_valid_ff;
   logic [1:0]  stage_op_ff;
   logic [15:0] stage_conn_ff;
   logic [31:0] stage_seq_ff;
   logic [9:0]  stage_length_ff;
   logic [7:0]  stage_handle_ff;

   // Link state.
   logic             link_up_ff, link_up_in;
   logic [31:0]      next_write_seq_ff, next_write_seq_in;
   logic [31:0]      last_recv_seq_ff, last_recv_seq_in;
   logic [31:0]      last_ack_seq_ff, last_ack_seq_in;
   logic [7:0]       idle_epochs_ff, idle_epochs_in;
   logic [31:0]      first_sent_seq_ff, first_sent_seq_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Queue RAM and forwarding of a write that lands on a read address.
   logic               ram_we;
   logic [IDX_W-1:0]   ram_wa;
   logic [ENTRY_W-1:0] ram_wd;
   logic [IDX_W-1:0]   ram_ra0, ram_ra1;
   logic [ENTRY_W-1:0] ram_rd0, ram_rd1;
   logic               fwd0_ff, fwd1_ff;
   logic [ENTRY_W-1:0] fwd_data_ff;
   logic [ENTRY_W-1:0] head0, head1;

   rsp_push_type push_c;

   slwc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_wa),
      .wr_data   (ram_wd),
      .rd_addr_a (ram_ra0),
      .rd_data_a (ram_rd0),
      .rd_addr_b (ram_ra1),
      .rd_data_b (ram_rd1)
   );

   assign head0 = fwd0_ff ? fwd_data_ff : ram_rd0;
   assign head1 = fwd1_ff ? fwd_data_ff : ram_rd1;
   assign busy  = stage_valid_ff;
   assign push  = push_c;

   // The RAM always reads the head the queue will have after this cycle,
   // and the entry behind it, so both are ready for the next request.
   assign ram_ra0 = head_in;
   assign ram_ra1 = next_idx(head_in);

   always_comb begin
      logic [CNT_W:0]   slot_sum;
      logic             reject;
      logic             wrote;
      logic             popped;
      logic             known;
      logic [1:0]       n;
      logic [31:0]      want;
      logic [ENTRY_W-1:0] first_entry;

      link_up_in        = link_up_ff;
      next_write_seq_in = next_write_seq_ff;
      last_recv_seq_in  = last_recv_seq_ff;
      last_ack_seq_in   = last_ack_seq_ff;
      idle_epochs_in    = idle_epochs_ff;
      first_sent_seq_in = first_sent_seq_ff;
      head_in           = head_ff;
      count_in          = count_ff;
      ram_we            = 1'b0;
      wrote             = 1'b0;
      popped            = 1'b0;
      known             = 1'b0;
      n                 = 2'd0;
      push_c            = '0;

      slot_sum = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
      if (slot_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         slot_sum = slot_sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      ram_wa = slot_sum[IDX_W-1:0];
      ram_wd = {next_write_seq_ff + 32'd1, stage_handle_ff};

      reject = (stage_length_ff == '0)
               || (32'(stage_length_ff) > 32'(MAX_PAYLOAD))
               || (32'(stage_handle_ff) >= 32'(HANDLE_COUNT))
               || (count_ff == CNT_W'(QUEUE_DEPTH));

      if (stage_valid_ff) begin
         unique case (stage_op_ff)
            OP_WRITE: begin
               known = 1'b1;
               if (reject) begin
                  push_c.item[n] = make_item(KIND_REJECT, '0, '0, '0);
                  n = n + 2'd1;
               end else begin
                  ram_we            = 1'b1;
                  wrote             = 1'b1;
                  next_write_seq_in = next_write_seq_ff + 32'd1;
                  count_in          = count_ff + 1'b1;
               end
            end
            OP_PACKET: begin
               known = 1'b1;
               if (link_up_ff && (stage_conn_ff == conn_id_ff)) begin
                  idle_epochs_in = '0;
                  if (stage_length_ff == '0) begin
                     // Ack: advance in order, pop the head it names.
                     if (stage_seq_ff == last_ack_seq_ff + 32'd1) begin
                        last_ack_seq_in = stage_seq_ff;
                     end
                     if ((count_ff != '0) && (stage_seq_ff == head0[ENTRY_W-1:8])) begin
                        popped   = 1'b1;
                        head_in  = next_idx(head_ff);
                        count_in = count_ff - 1'b1;
                     end
                  end else if (stage_seq_ff == last_recv_seq_ff + 32'd1) begin
                     last_recv_seq_in = stage_seq_ff;
                     push_c.item[n] = make_item(KIND_DELIVER, stage_seq_ff, conn_id_ff,
                                                stage_handle_ff);
                     n = n + 2'd1;
                     push_c.item[n] = make_item(KIND_ACK, stage_seq_ff, conn_id_ff, '0);
                     n = n + 2'd1;
                  end
               end
            end
            OP_TICK: begin
               known = 1'b1;
               if (link_up_ff) begin
                  push_c.item[n] = make_item(KIND_ACK, last_recv_seq_ff, conn_id_ff, '0);
                  n = n + 2'd1;
                  if (count_ff != '0) begin
                     push_c.item[n] = make_item(KIND_SEND, head0[ENTRY_W-1:8], conn_id_ff,
                                                head0[7:0]);
                     n = n + 2'd1;
                  end
                  idle_epochs_in = idle_epochs_ff + 8'd1;
                  if (idle_epochs_in >= epoch_limit_ff) begin
                     link_up_in = 1'b0;
                     push_c.item[n] = make_item(KIND_DOWN, '0, '0, '0);
                     n = n + 2'd1;
                  end
               end
            end
            default: begin
               known = 1'b0;
            end
         endcase

         // First transmission of the head once the previous message is acked.
         want = last_ack_seq_in + 32'd1;
         if (wrote && (count_ff == '0)) begin
            first_entry = ram_wd;
         end else if (popped) begin
            first_entry = head1;
         end else begin
            first_entry = head0;
         end
         if (known && link_up_in && (count_in != '0) && (want > first_sent_seq_ff)) begin
            push_c.item[n] = make_item(KIND_SEND, first_entry[ENTRY_W-1:8], conn_id_ff,
                                       first_entry[7:0]);
            n = n + 2'd1;
            first_sent_seq_in = first_entry[ENTRY_W-1:8];
         end

         if (n != 2'd0) begin
            push_c.item[n - 2'd1].last = 1'b1;
         end
         push_c.count = n;
      end else begin
         want        = '0;
         first_entry = '0;
      end
   end

   always_ff @(posedge clock) begin
      stage_op_ff     <= in_accept ? in_op     : stage_op_ff;
      stage_conn_ff   <= in_accept ? in_conn   : stage_conn_ff;
      stage_seq_ff    <= in_accept ? in_seq    : stage_seq_ff;
      stage_length_ff <= in_accept ? in_length : stage_length_ff;
      stage_handle_ff <= in_accept ? in_handle : stage_handle_ff;
      fwd_data_ff     <= ram_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_limit_ff    <= 8'd5;
         conn_id_ff        <= '0;
         stage_valid_ff    <= 1'b0;
         link_up_ff        <= 1'b1;
         next_write_seq_ff <= '0;
         last_recv_seq_ff  <= '0;
         last_ack_seq_ff   <= '0;
         idle_epochs_ff    <= '0;
         first_sent_seq_ff <= '0;
         head_ff           <= '0;
         count_ff          <= '0;
         fwd0_ff           <= 1'b0;
         fwd1_ff           <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_EPOCH_LIMIT: epoch_limit_ff <= csr_wdata[7:0];
               CSR_CONN_ID:     conn_id_ff     <= csr_wdata;
               default:         epoch_limit_ff <= epoch_limit_ff;
            endcase
         end
         stage_valid_ff    <= in_accept;
         link_up_ff        <= link_up_in;
         next_write_seq_ff <= next_write_seq_in;
         last_recv_seq_ff  <= last_recv_seq_in;
         last_ack_seq_ff   <= last_ack_seq_in;
         idle_epochs_ff    <= idle_epochs_in;
         first_sent_seq_ff <= first_sent_seq_in;
         head_ff           <= head_in;
         count_ff          <= count_in;
         fwd0_ff           <= ram_we && (ram_wa == ram_ra0);
         fwd1_ff           <= ram_we && (ram_wa == ram_ra1);
      end
   end

endmodule

`default_nettype wire

@@ rtl/stop_and_wait_link_client.sv @@
// Stop-and-wait link client. A request is registered in the core's stage, and its
// results are written to the result queue, from which they are offered on rsp.
// Throughput: one request a cycle, bounded by the response port, which drains one
// result a cycle while rsp_tready is high (up to three per request). Reset is
// synchronous and active high; the payload queue RAM is not cleared, since an entry
// is only read after it has been written. Depends on slwc_pkg and submodules.
`default_nettype none

module stop_and_wait_link_client #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   // Configuration write port: index 0 epoch_limit, index 1 conn_id.
   input  wire logic                            csr_wr_en,
   input  wire logic [0:0]                      csr_index,
   input  wire logic [15:0]                     csr_wdata,

   // Request channel.
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata from bit 0 up: pkt_conn[15:0], pkt_seq[47:16], payload_length[57:48],
   // payload_handle[65:58], zero fill.
   input  wire logic [slwc_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: op[1:0].
   input  wire logic [1:0]                      req_tuser,

   // Response channel.
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata from bit 0 up: kind[2:0], seq[34:3], out_conn[50:35], out_handle[58:51],
   // zero fill.
   output logic [slwc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);
   import slwc_pkg::*;

   logic                 req_accept;
   logic                 core_busy;
   rsp_push_type         push;
   rsp_item_type         out_item;
   logic [RSP_CNT_W-1:0] fill;

   // A request is taken only while the result queue is sure to have room for
   // its results plus those of the request the core is working on this cycle.
   assign req_tready = core_busy ? (fill <= RSP_CNT_W'(RSP_DEPTH - 6))
                                 : (fill <= RSP_CNT_W'(RSP_DEPTH - 3));
   assign req_accept = req_tvalid && req_tready;

   slwc_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_accept (req_accept),
      .in_op     (req_tuser),
      .in_conn   (req_tdata[15:0]),
      .in_seq    (req_tdata[47:16]),
      .in_length (req_tdata[57:48]),
      .in_handle (req_tdata[65:58]),
      .busy      (core_busy),
      .push      (push)
   );

   slwc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item),
      .fill      (fill)
   );

   assign rsp_tdata = {5'd0, out_item.handle, out_item.conn, out_item.seq, out_item.kind};
   assign rsp_tlast = out_item.last;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the stop-and-wait link client, driven over its request,
// response and register ports. Depends on slwc_pkg and the stop_and_wait_link_client RTL.
// A directed request table comes first, followed by random phases under several settings.

module tb_top;
   import slwc_pkg::*;

   // The DUT is built with its default queue depth. The model below relies on a
   // depth of sixteen, because its slot pointer wraps as a 4-bit count.
   localparam int LINK_QDEPTH = 16;

   // Op code 3 is not defined by the package. The block must ignore it.
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_HOLD   = 300;
   localparam int DRAIN_SETTLE = 12;
   localparam int DRAIN_WAIT   = 5000;
   localparam int PRINT_CAP    = 40;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [0:0]            csr_index;
   logic [15:0]           csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   // tdata from bit 0 up: pkt_conn, pkt_seq, payload_length, payload_handle, zero fill.
   logic [REQ_DATA_W-1:0] req_tdata;
   // tuser: op.
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // tdata from bit 0 up: kind, seq, out_conn, out_handle, zero fill.
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   stop_and_wait_link_client #(.QUEUE_DEPTH(LINK_QDEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // The run is cut off here if the block hangs or drops a handshake.
   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Link model. It holds its own copy of the registers and of the link state.
   // Each accepted request is applied here, and the model leaves its results in
   // step_rsp, in the order the block must send them.
   // -------------------------------------------------------------------------
   logic [7:0]   cfg_epoch_limit;
   logic [15:0]  cfg_conn;
   bit           lk_up;
   logic [31:0]  wr_seq;
   logic [31:0]  rx_seq;
   logic [31:0]  ack_seq;
   logic [7:0]   idle_cnt;
   logic [31:0]  sent_seq;
   logic [31:0]  slot_seq [LINK_QDEPTH];
   logic [7:0]   slot_handle [LINK_QDEPTH];
   logic [3:0]   slot_head;
   logic [4:0]   slot_count;

   rsp_item_type step_rsp[$];
   rsp_item_type awaited_rsp[$];
   int           mismatch_count = 0;

   function automatic void add_result(kind_type k, logic [31:0] s, logic [15:0] c,
                                      logic [7:0] h);
      rsp_item_type r;
      r.kind   = k;
      r.seq    = s;
      r.conn   = c;
      r.handle = h;
      r.last   = 1'b0;
      step_rsp.push_back(r);
   endfunction

   function automatic void link_predict(logic [1:0] op, logic [15:0] conn, logic [31:0] seq,
                                        logic [9:0] len, logic [7:0] handle);
      logic [3:0]   slot;
      rsp_item_type r;
      step_rsp.delete();
      if (op == OP_WRITE) begin
         // A write is queued even while the link is down. It is refused only when it
         // is empty, out of range, or when the queue is full.
         if (len == 0 || len > MAX_PAYLOAD || handle >= HANDLE_COUNT ||
             slot_count >= LINK_QDEPTH) begin
            add_result(KIND_REJECT, 32'd0, 16'd0, 8'd0);
         end else begin
            slot = slot_head + slot_count[3:0];
            wr_seq = wr_seq + 32'd1;
            slot_seq[slot] = wr_seq;
            slot_handle[slot] = handle;
            slot_count = slot_count + 5'd1;
         end
      end else if (op == OP_PACKET) begin
         // Packets for another connection, and every packet after link down, vanish.
         if (lk_up && conn == cfg_conn) begin
            idle_cnt = 8'd0;
            if (len == 0) begin
               if (seq == ack_seq + 32'd1)
                  ack_seq = seq;
               if (slot_count > 0 && seq == slot_seq[slot_head]) begin
                  slot_head = slot_head + 4'd1;
                  slot_count = slot_count - 5'd1;
               end
            end else if (seq == rx_seq + 32'd1) begin
               rx_seq = seq;
               add_result(KIND_DELIVER, seq, cfg_conn, handle);
               add_result(KIND_ACK, rx_seq, cfg_conn, 8'd0);
            end
         end
      end else if (op == OP_TICK) begin
         if (lk_up) begin
            add_result(KIND_ACK, rx_seq, cfg_conn, 8'd0);
            if (slot_count > 0)
               add_result(KIND_SEND, slot_seq[slot_head], cfg_conn, slot_handle[slot_head]);
            idle_cnt = idle_cnt + 8'd1;
            if (idle_cnt >= cfg_epoch_limit) begin
               lk_up = 1'b0;
               add_result(KIND_DOWN, 32'd0, 16'd0, 8'd0);
            end
         end
      end
      // The queue head goes out for the first time once the previous message has
      // been acked. The compare is unsigned and wraps at 32 bits.
      if (op != OP_RESERVED && lk_up && slot_count > 0 && (ack_seq + 32'd1) > sent_seq) begin
         add_result(KIND_SEND, slot_seq[slot_head], cfg_conn, slot_handle[slot_head]);
         sent_seq = slot_seq[slot_head];
      end
      if (step_rsp.size() > 0) begin
         r = step_rsp.pop_back();
         r.last = 1'b1;
         step_rsp.push_back(r);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Checking. Every result is compared field by field with the oldest one that
   // is still awaited. Printing stops after a while, but counting does not.
   // -------------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0d: %s: got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
      mismatch_count = mismatch_count + 1;
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind   = kind_type'(rsp_tdata[2:0]);
         got.seq    = rsp_tdata[34:3];
         got.conn   = rsp_tdata[50:35];
         got.handle = rsp_tdata[58:51];
         got.last   = rsp_tlast;
         if (awaited_rsp.size() == 0) begin
            report_mismatch("result with nothing awaited, kind", 32'(got.kind), 32'd0);
         end else begin
            want = awaited_rsp.pop_front();
            if (got.kind != want.kind)
               report_mismatch("kind", 32'(got.kind), 32'(want.kind));
            if (got.seq != want.seq)
               report_mismatch("seq", got.seq, want.seq);
            if (got.conn != want.conn)
               report_mismatch("out_conn", 32'(got.conn), 32'(want.conn));
            if (got.handle != want.handle)
               report_mismatch("out_handle", 32'(got.handle), 32'(want.handle));
            if (got.last != want.last)
               report_mismatch("last", 32'(got.last), 32'(want.last));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response side. After each accepted result the receiver may stall for a random
   // while. On request from the stimulus process it holds off for a long
   // stretch instead, so that the block fills up and stalls its request input.
   // -------------------------------------------------------------------------
   bit drain_gaps_on  = 1'b1;
   bit drain_hold_req = 1'b0;
   bit sender_gaps_on = 1'b1;

   initial begin : rsp_drain
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            stall = drain_gaps_on ? $urandom_range(0, 10) : 0;
         if (drain_hold_req) begin
            drain_hold_req = 1'b0;
            stall = DRAIN_HOLD;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall = stall - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side. A request is offered at a falling edge and held until a rising
   // edge sees tready. The task returns at the next falling edge with tvalid still
   // high, so the request that follows can go out without a bubble.
   // -------------------------------------------------------------------------
   task automatic send_request(logic [1:0] op, logic [15:0] conn, logic [31:0] seq,
                               logic [9:0] len, logic [7:0] handle);
      int gap;
      gap = sender_gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {6'd0, handle, len, seq, conn};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Lower tvalid and let every awaited result come back. Then give the pipeline
   // a settling wait, since the last request may not have caused any result.
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (awaited_rsp.size() > 0 && waited < DRAIN_WAIT) begin
         @(negedge clock);
         waited = waited + 1;
      end
      repeat (DRAIN_SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Directed request table. A row with a typed result is checked against that
   // result. Every other row is checked against the model.
   // -------------------------------------------------------------------------
   typedef struct {
      logic [1:0]   op;
      logic [15:0]  conn;
      logic [31:0]  seq;
      logic [9:0]   len;
      logic [7:0]   handle;
      bit           typed;
      int           typed_n;
      rsp_item_type typed_rsp;
   } stim_row_type;

   stim_row_type dir_rows[$];

   function automatic void add_row(logic [1:0] op, logic [15:0] conn, logic [31:0] seq,
                                   logic [9:0] len, logic [7:0] handle);
      stim_row_type row;
      row.op = op;
      row.conn = conn;
      row.seq = seq;
      row.len = len;
      row.handle = handle;
      row.typed = 1'b0;
      row.typed_n = 0;
      row.typed_rsp = '0;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_typed(logic [1:0] op, logic [15:0] conn, logic [31:0] seq,
                                     logic [9:0] len, logic [7:0] handle, int n,
                                     kind_type k, logic [31:0] t_seq, logic [15:0] t_conn,
                                     logic [7:0] t_handle);
      stim_row_type row;
      row.op = op;
      row.conn = conn;
      row.seq = seq;
      row.len = len;
      row.handle = handle;
      row.typed = 1'b1;
      row.typed_n = n;
      row.typed_rsp.kind = k;
      row.typed_rsp.seq = t_seq;
      row.typed_rsp.conn = t_conn;
      row.typed_rsp.handle = t_handle;
      row.typed_rsp.last = 1'b1;
      dir_rows.push_back(row);
   endfunction

   // -------------------------------------------------------------------------
   // Random phase. The registers are written while the block is idle, and then
   // requests are drawn with weights for writes, packets and ticks. Packets are
   // mostly well formed: they carry our connection id and the sequence number that
   // the link is waiting for, so that acks pop the queue and data gets delivered.
   // Every request sent counts toward the quota, including those the block ignores.
   // -------------------------------------------------------------------------
   task automatic run_phase(logic [7:0] limit, logic [15:0] conn, int quota, int w_write,
                            int w_packet, int w_tick, bit s_gaps, bit d_gaps, bit hold);
      int          done;
      int          pick;
      int          roll;
      logic [1:0]  op;
      logic [15:0] pconn;
      logic [31:0] pseq;
      logic [9:0]  plen;
      logic [7:0]  phandle;
      wait_drained();
      write_csr(CSR_EPOCH_LIMIT, {8'd0, limit});
      cfg_epoch_limit = limit;
      write_csr(CSR_CONN_ID, conn);
      cfg_conn = conn;
      sender_gaps_on = s_gaps;
      drain_gaps_on = d_gaps;
      if (hold)
         drain_hold_req = 1'b1;
      done = 0;
      while (done < quota) begin
         pick = $urandom_range(0, 99);
         pconn = 16'($urandom);
         pseq = $urandom;
         plen = 10'($urandom);
         phandle = 8'($urandom);
         if (pick < w_write) begin
            op = OP_WRITE;
            if ($urandom_range(0, 9) == 0)
               plen = 10'd0;
            else
               plen = 10'($urandom_range(1, 1023));
         end else if (pick < w_write + w_packet) begin
            op = OP_PACKET;
            if ($urandom_range(0, 99) < 85)
               pconn = cfg_conn;
            if ($urandom_range(0, 1) == 0) begin
               // An ack: usually the next in order or the current queue head.
               plen = 10'd0;
               roll = $urandom_range(0, 9);
               if (roll < 6)
                  pseq = ack_seq + 32'd1;
               else if (roll < 8 && slot_count > 0)
                  pseq = slot_seq[slot_head];
            end else begin
               plen = 10'($urandom_range(1, 1023));
               if ($urandom_range(0, 3) != 0)
                  pseq = rx_seq + 32'd1;
            end
         end else if (pick < w_write + w_packet + w_tick) begin
            op = OP_TICK;
         end else begin
            op = OP_RESERVED;
         end
         send_request(op, pconn, pseq, plen, phandle);
         link_predict(op, pconn, pseq, plen, phandle);
         foreach (step_rsp[k])
            awaited_rsp.push_back(step_rsp[k]);
         done = done + 1;
      end
   endtask

   initial begin : stimulus
      stim_row_type row;
      rsp_item_type missing;
      reset      = 1'b1;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_EPOCH_LIMIT;
      csr_wdata  = 16'd0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_WRITE;

      // The model starts from the reset state of the block.
      cfg_epoch_limit = 8'd5;
      cfg_conn   = 16'd0;
      lk_up      = 1'b1;
      wr_seq     = 32'd0;
      rx_seq     = 32'd0;
      ack_seq    = 32'd0;
      idle_cnt   = 8'd0;
      sent_seq   = 32'd0;
      slot_head  = 4'd0;
      slot_count = 5'd0;
      foreach (slot_seq[k]) begin
         slot_seq[k] = 32'd0;
         slot_handle[k] = 8'd0;
      end

      // Directed part, run with the reset settings: epoch limit 5 and connection 0.
      // A tick right after reset acks sequence 0 and has nothing to resend.
      add_typed(OP_TICK, 16'd0, 32'd0, 10'd0, 8'd0, 1, KIND_ACK, 32'd0, 16'd0, 8'd0);
      // An empty write is rejected.
      add_typed(OP_WRITE, 16'd0, 32'd0, 10'd0, 8'h5A, 1, KIND_REJECT, 32'd0, 16'd0, 8'd0);
      // The first write takes sequence 1 and goes out at once. The packet fields are
      // all ones here, and the block ignores them for a write.
      add_typed(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 10'd1023, 8'hFF, 1,
                KIND_SEND, 32'd1, 16'd0, 8'hFF);
      // The second write waits in the queue until the first one is acked.
      add_row(OP_WRITE, 16'd0, 32'd0, 10'd1, 8'h00);
      add_row(OP_PACKET, 16'd0, 32'd1, 10'd0, 8'd0);
      // An ack for a foreign connection changes nothing.
      add_typed(OP_PACKET, 16'hFFFF, 32'd2, 10'd0, 8'd0, 0, KIND_ACK, 32'd0, 16'd0, 8'd0);
      // In-order data, then a duplicate, then data far out of order.
      add_row(OP_PACKET, 16'd0, 32'd1, 10'd5, 8'hAA);
      add_row(OP_PACKET, 16'd0, 32'd1, 10'd5, 8'h11);
      add_row(OP_PACKET, 16'd0, 32'hFFFF_FFFF, 10'd1023, 8'hFF);
      // A tick re-acks the last data and resends the queue head.
      add_row(OP_TICK, 16'd0, 32'd0, 10'd0, 8'd0);
      add_row(OP_PACKET, 16'd0, 32'd2, 10'd0, 8'd0);
      // The undefined op code is ignored.
      add_typed(OP_RESERVED, 16'hFFFF, 32'hFFFF_FFFF, 10'h3FF, 8'hFF, 0,
                KIND_ACK, 32'd0, 16'd0, 8'd0);
      add_row(OP_WRITE, 16'd0, 32'd0, 10'd512, 8'h55);
      add_row(OP_WRITE, 16'd0, 32'd0, 10'd2, 8'hAA);
      add_row(OP_WRITE, 16'd0, 32'd0, 10'd1023, 8'h01);
      add_row(OP_WRITE, 16'd0, 32'd0, 10'd77, 8'h80);
      // A stale ack only clears the idle count.
      add_row(OP_PACKET, 16'd0, 32'd0, 10'd0, 8'd0);
      add_row(OP_TICK, 16'd0, 32'd0, 10'd0, 8'd0);
      add_row(OP_PACKET, 16'd0, 32'd2, 10'd1, 8'h3C);
      add_row(OP_PACKET, 16'd0, 32'd3, 10'd0, 8'd0);
      add_row(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 10'h3FF, 8'hFF);
      add_row(OP_PACKET, 16'hFFFF, 32'd3, 10'd9, 8'h42);
      add_row(OP_PACKET, 16'd0, 32'hFFFF_FFFF, 10'd0, 8'd0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_request(row.op, row.conn, row.seq, row.len, row.handle);
         link_predict(row.op, row.conn, row.seq, row.len, row.handle);
         if (row.typed) begin
            if (row.typed_n == 1)
               awaited_rsp.push_back(row.typed_rsp);
         end else begin
            foreach (step_rsp[k])
               awaited_rsp.push_back(step_rsp[k]);
         end
      end

      // Random phases. The link going down cannot be undone without a reset, so it
      // comes last. An epoch limit of one is used only in a phase without ticks.
      run_phase(8'd255, 16'hFFFF, 60, 35, 50, 13, 1'b1, 1'b1, 1'b1);
      run_phase(8'd1, 16'($urandom), 45, 40, 58, 0, 1'b0, 1'b0, 1'b0);
      run_phase(8'd200, 16'h0000, 55, 60, 30, 8, 1'b1, 1'b0, 1'b0);
      run_phase(8'($urandom_range(100, 255)), 16'($urandom), 60, 35, 50, 13,
                1'b0, 1'b1, 1'b1);
      // With an epoch limit of zero the first tick takes the link down. After that,
      // writes are still queued until the queue is full, and everything else is dropped.
      run_phase(8'd0, 16'h5AA5, 40, 60, 25, 13, 1'b1, 1'b1, 1'b0);

      wait_drained();
      while (awaited_rsp.size() > 0) begin
         missing = awaited_rsp.pop_front();
         report_mismatch("result never arrived, kind", 32'(missing.kind), 32'd0);
      end

      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
